>>> rtl/core/mme_pkg.sv
// Types and constants shared by the matrix multiply engine.
// Request, response and pipeline tag structs; command and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;
	localparam int DIM_W  = 4;
	localparam int ACC_W  = 72;

	localparam logic [1:0] CMD_WR_A = 2'd0;
	localparam logic [1:0] CMD_WR_B = 2'd1;
	localparam logic [1:0] CMD_MUL  = 2'd2;

	localparam logic [2:0] REG_A_ROWS = 3'd0;
	localparam logic [2:0] REG_A_COLS = 3'd1;
	localparam logic [2:0] REG_B_ROWS = 3'd2;
	localparam logic [2:0] REG_B_COLS = 3'd3;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        col_index;
		logic signed [DATA_W-1:0] element_value;
	} mme_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product_value;
		logic [IDX_W-1:0]        out_row;
		logic [IDX_W-1:0]        out_col;
		logic                    last_element;
		logic                    dim_error;
	} mme_rsp_t;

	// travels alongside each multiply-accumulate step
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last_el;
	} mme_tag_t;

endpackage

`default_nettype wire

>>> rtl/core/matrix_multiply_engine_unit.sv
// Matrix multiply engine top level: command sequencer, A and B stores,
// result register. Depends on mme_pkg, mme_store and mme_mac.
//
// Usage:
//  cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets a_rows, a_cols,
//  b_rows, b_cols; cfg_ready is always high. Write only while idle.
//  req channel carries one command: write an A element, write a B element,
//  or multiply. Writes give no response; writes outside the configured
//  size are dropped. A multiply walks the shared MAC over the inner
//  dimension for every result, reading one word from each store per cycle
//  unless the output stalls. A size mismatch gives one response with
//  dim_error and last_element set.
//  rsp channel holds each response in a register; a stalled receiver freezes
//  the MAC pipeline, nothing is lost. req_ready is low while a run issues.
//  Reset (arst_n low) clears control and sets each dimension to 3; the stores
//  are not cleared and hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_engine_unit #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [3:0]        cfg_data,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire mme_pkg::mme_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output mme_pkg::mme_rsp_t      rsp
);
	import mme_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'((MAX_DIM > 15) ? 15 : MAX_DIM);
	localparam logic [AW-1:0]    STRIDE  = AW'(MAX_DIM);
	localparam logic [7:0]       RESULT_LIMIT = 8'd64;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		if (r == '0) begin
			return DIM_W'(1);
		end else if (r > DIM_MAX) begin
			return DIM_MAX;
		end
		return r;
	endfunction

	logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [DIM_W-1:0] ar, ac, br, bc;
	logic [1:0]       state_q;
	logic [DIM_W-1:0] i_q, j_q, k_q;
	logic [6:0]       n_q;
	logic [7:0]       total;
	logic [7:0]       area;
	logic             k_last, j_last, last_el;
	logic             req_fire, adv, err_load, dim_bad;
	logic             a_wr, b_wr, rd_en;
	logic [AW-1:0]    wr_addr, a_rd_addr, b_rd_addr;
	logic [31:0]      a_rd, b_rd;
	mme_tag_t         tag_s1_q;
	logic             res_valid;
	mme_rsp_t         res;
	logic             mac_busy;
	logic             rsp_valid_q;
	mme_rsp_t         rsp_q;

	assign ar = eff_dim(a_rows_q);
	assign ac = eff_dim(a_cols_q);
	assign br = eff_dim(b_rows_q);
	assign bc = eff_dim(b_cols_q);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_RESET;
			a_cols_q <= DIM_RESET;
			b_rows_q <= DIM_RESET;
			b_cols_q <= DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_A_ROWS: a_rows_q <= cfg_data;
				REG_A_COLS: a_cols_q <= cfg_data;
				REG_B_ROWS: b_rows_q <= cfg_data;
				REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign dim_bad   = (ac != br);

	// stores are written only while idle, so reads of a run never meet a write
	assign a_wr = req_fire && (req.cmd == CMD_WR_A) &&
		({1'b0, req.row_index} < ar) && ({1'b0, req.col_index} < ac);
	assign b_wr = req_fire && (req.cmd == CMD_WR_B) &&
		({1'b0, req.row_index} < br) && ({1'b0, req.col_index} < bc);
	assign wr_addr = AW'(AW'(req.row_index) * STRIDE + AW'(req.col_index));

	assign a_rd_addr = AW'(AW'(i_q) * STRIDE + AW'(k_q));
	assign b_rd_addr = AW'(AW'(k_q) * STRIDE + AW'(j_q));

	assign area    = {4'b0, ar} * {4'b0, bc};
	assign total   = (area > RESULT_LIMIT) ? RESULT_LIMIT : area;
	assign k_last  = (k_q == ac - DIM_W'(1));
	assign j_last  = (j_q == bc - DIM_W'(1));
	assign last_el = ({1'b0, n_q} + 8'd1 == total);

	// pipeline freezes only when a finished sum cannot move to the output
	assign adv      = !(res_valid && rsp_valid_q && !rsp_ready);
	assign rd_en    = adv && (state_q == ST_RUN);
	assign err_load = (state_q == ST_ERR) && !tag_s1_q.valid && !mac_busy &&
		(!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			n_q      <= '0;
			tag_s1_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (adv) begin
						tag_s1_q.valid <= 1'b0;
					end
					if (req_fire && req.cmd == CMD_MUL) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						n_q     <= '0;
						state_q <= dim_bad ? ST_ERR : ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv) begin
						tag_s1_q.valid   <= 1'b1;
						tag_s1_q.first   <= (k_q == '0);
						tag_s1_q.last    <= k_last;
						tag_s1_q.row     <= i_q[IDX_W-1:0];
						tag_s1_q.col     <= j_q[IDX_W-1:0];
						tag_s1_q.last_el <= last_el;
						if (k_last) begin
							k_q <= '0;
							n_q <= n_q + 7'd1;
							if (j_last) begin
								j_q <= '0;
								i_q <= i_q + DIM_W'(1);
							end else begin
								j_q <= j_q + DIM_W'(1);
							end
							if (last_el) begin
								state_q <= ST_IDLE;
							end
						end else begin
							k_q <= k_q + DIM_W'(1);
						end
					end
				end
				ST_ERR: begin
					if (adv) begin
						tag_s1_q.valid <= 1'b0;
					end
					if (err_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					tag_s1_q.valid <= 1'b0;
					state_q        <= ST_IDLE;
				end
			endcase
		end
	end

	mme_store #(.DEPTH(DEPTH), .AW(AW), .W(DATA_W)) u_a_store (
		.clk     (clk),
		.wr_en   (a_wr),
		.wr_addr (wr_addr),
		.wr_data (req.element_value),
		.rd_en   (rd_en),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd)
	);

	mme_store #(.DEPTH(DEPTH), .AW(AW), .W(DATA_W)) u_b_store (
		.clk     (clk),
		.wr_en   (b_wr),
		.wr_addr (wr_addr),
		.wr_data (req.element_value),
		.rd_en   (rd_en),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd)
	);

	mme_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.tag_s1    (tag_s1_q),
		.a_data    (a_rd),
		.b_data    (b_rd),
		.res_valid (res_valid),
		.res       (res),
		.busy      (mac_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((res_valid && adv) || err_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && adv) begin
			rsp_q <= res;
		end else if (err_load) begin
			rsp_q.product_value <= '0;
			rsp_q.out_row       <= '0;
			rsp_q.out_col       <= '0;
			rsp_q.last_element  <= 1'b1;
			rsp_q.dim_error     <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_mismatch_to_err: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req.cmd == CMD_MUL && dim_bad |=> state_q == ST_ERR)
		else $error("size mismatch did not enter error state");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !adv |=> res_valid && $stable(res))
		else $error("finished sum lost during output stall");

	a_err_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.dim_error |-> rsp_q.last_element && rsp_q.product_value == 0)
		else $error("error response malformed");

	a_err_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		err_load |-> !res_valid && !tag_s1_q.valid)
		else $error("error response overtook pending results");
`endif

endmodule

`default_nettype wire

>>> rtl/core/mme_store.sv
// Single-port-write, single-port-read synchronous store with registered read data.
// Holds one matrix; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mme_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int W     = 32
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [W-1:0]  wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [W-1:0]  rd_data
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mme_mac.sv
// Shared multiply-accumulate datapath: product stage, exact accumulator,
// floor shift and 32-bit saturation. Depends on mme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mme_mac #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire mme_pkg::mme_tag_t tag_s1,
	input  wire logic [31:0]     a_data,
	input  wire logic [31:0]     b_data,
	output logic                 res_valid,
	output mme_pkg::mme_rsp_t    res,
	output logic                 busy
);
	import mme_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'h7fffffff);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

	mme_tag_t                 tag_s2;
	logic signed [63:0]       prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  sum;
	logic signed [ACC_W-1:0]  res_sum_q;
	logic signed [ACC_W-1:0]  shifted;
	mme_tag_t                 res_tag_q;
	logic                     res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2      <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			tag_s2      <= tag_s1;
			res_valid_q <= tag_s2.valid && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= $signed(a_data) * $signed(b_data);
		end
	end

	always_comb begin
		sum = (tag_s2.first ? '0 : acc_q) + {{(ACC_W-64){prod_s2[63]}}, prod_s2};
	end

	always_ff @(posedge clk) begin
		if (adv && tag_s2.valid) begin
			acc_q <= sum;
			if (tag_s2.last) begin
				res_sum_q <= sum;
				res_tag_q <= tag_s2;
			end
		end
	end

	always_comb begin
		shifted           = res_sum_q >>> FRAC_BITS;
		res.out_row       = res_tag_q.row;
		res.out_col       = res_tag_q.col;
		res.last_element  = res_tag_q.last_el;
		res.dim_error     = 1'b0;
		if (shifted > SAT_MAX) begin
			res.product_value = 32'sh7fffffff;
		end else if (shifted < SAT_MIN) begin
			res.product_value = 32'sh80000000;
		end else begin
			res.product_value = shifted[31:0];
		end
	end

	assign res_valid = res_valid_q;
	assign busy      = tag_s2.valid || res_valid_q;

endmodule

`default_nettype wire

>>> bench/matrix_multiply_engine_unit_tb.sv
// Self-checking bench for matrix_multiply_engine_unit: a directed table with hand-written expected
// products, then random load/multiply phases checked against an in-bench Q16.16 product predictor.
// Depends on mme_pkg and the engine RTL only.
`timescale 1ns / 1ps

module matrix_multiply_engine_unit_tb;

	import mme_pkg::*;

	localparam int FRAC      = 16;
	localparam int DIM_MAX   = 8;
	localparam int ITEM_GOAL = 120;
	localparam int SETTLE    = 16;
	localparam int LIMIT_NS  = 2_000_000;

	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct {
		bit         is_cfg;
		logic [2:0] cfg_idx;
		logic [3:0] cfg_val;
		mme_req_t   item;
		bit         typed;
		mme_rsp_t   want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;
	logic       req_valid = 1'b0;
	mme_req_t   req = '0;
	logic       rsp_ready = 1'b0;
	logic       cfg_ready;
	logic       req_ready;
	logic       rsp_valid;
	mme_rsp_t   rsp;

	// predictor state
	logic signed [31:0] a_mem [64];
	logic signed [31:0] b_mem [64];
	bit                 a_set [64];
	bit                 b_set [64];
	logic [3:0]         dim_reg [4] = '{DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};

	mme_rsp_t products_due [$];
	dir_row_t dir_tab [$];
	int       bad_cnt = 0;
	int       live_cnt = 0;
	int       rx_hold = 0;
	bit       no_idle = 1'b0;
	bit       req_busy = 1'b0;

	matrix_multiply_engine_unit #(
		.MAX_DIM(DIM_MAX),
		.FRAC_BITS(FRAC)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("matrix_multiply_engine_unit_tb failed");
		$finish;
	end

	function automatic int eff_dim(logic [3:0] d);
		if (d == 0) return 1;
		if (d > DIM_MAX) return DIM_MAX;
		return int'(d);
	endfunction

	function automatic logic signed [31:0] dot_q16(int row, int col, int inner);
		logic signed [79:0] acc;
		int k;
		acc = '0;
		for (k = 0; k < inner; k++)
			acc = acc + a_mem[{3'(row), 3'(k)}] * b_mem[{3'(k), 3'(col)}];
		acc = acc >>> FRAC;
		if (acc > 80'sd2147483647) return 32'h7FFF_FFFF;
		if (acc < -80'sd2147483648) return 32'h8000_0000;
		return acc[31:0];
	endfunction

	// returns 1 when the request changes state or produces results
	function automatic bit apply_request(mme_req_t q);
		int ar, ac, br, bc, i, j;
		mme_rsp_t o;
		ar = eff_dim(dim_reg[REG_A_ROWS]);
		ac = eff_dim(dim_reg[REG_A_COLS]);
		br = eff_dim(dim_reg[REG_B_ROWS]);
		bc = eff_dim(dim_reg[REG_B_COLS]);
		case (q.cmd)
			CMD_WR_A: begin
				if (q.row_index >= ar || q.col_index >= ac) return 1'b0;
				a_mem[{q.row_index, q.col_index}] = q.element_value;
				a_set[{q.row_index, q.col_index}] = 1'b1;
				return 1'b1;
			end
			CMD_WR_B: begin
				if (q.row_index >= br || q.col_index >= bc) return 1'b0;
				b_mem[{q.row_index, q.col_index}] = q.element_value;
				b_set[{q.row_index, q.col_index}] = 1'b1;
				return 1'b1;
			end
			CMD_MUL: begin
				if (ac != br) begin
					o = '0;
					o.last_element = 1'b1;
					o.dim_error = 1'b1;
					products_due.push_back(o);
					return 1'b1;
				end
				for (i = 0; i < ar; i++) begin
					for (j = 0; j < bc; j++) begin
						o.product_value = dot_q16(i, j, ac);
						o.out_row = 3'(i);
						o.out_col = 3'(j);
						o.last_element = (i == ar - 1) && (j == bc - 1);
						o.dim_error = 1'b0;
						products_due.push_back(o);
					end
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void check_product(mme_rsp_t got);
		mme_rsp_t want;
		if (products_due.size() == 0) begin
			bad_cnt++;
			if (bad_cnt <= 10)
				$display("unexpected product: %h r%0d c%0d last %b err %b",
					got.product_value, got.out_row, got.out_col, got.last_element,
					got.dim_error);
			return;
		end
		want = products_due.pop_front();
		if (got.product_value !== want.product_value || got.out_row !== want.out_row ||
				got.out_col !== want.out_col || got.last_element !== want.last_element ||
				got.dim_error !== want.dim_error) begin
			bad_cnt++;
			if (bad_cnt <= 10)
				$display({"product mismatch: want %h r%0d c%0d last %b err %b, ",
					"got %h r%0d c%0d last %b err %b"},
					want.product_value, want.out_row, want.out_col, want.last_element,
					want.dim_error, got.product_value, got.out_row, got.out_col,
					got.last_element, got.dim_error);
		end
	endfunction

	function automatic mme_req_t make_req(logic [1:0] cmd, int row, int col, logic [31:0] val);
		mme_req_t q;
		q.cmd = cmd;
		q.row_index = 3'(row);
		q.col_index = 3'(col);
		q.element_value = val;
		return q;
	endfunction

	function automatic dir_row_t cfg_row(logic [2:0] idx, logic [3:0] val);
		dir_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	function automatic dir_row_t req_row(logic [1:0] cmd, int row, int col, logic [31:0] val);
		dir_row_t r;
		r = '{default: '0};
		r.item = make_req(cmd, row, col, val);
		return r;
	endfunction

	function automatic dir_row_t mul_row(logic [31:0] want_val, logic err);
		dir_row_t r;
		r = req_row(CMD_MUL, 7, 7, 32'hDEAD_BEEF);
		r.typed = 1'b1;
		r.want.product_value = want_val;
		r.want.out_row = '0;
		r.want.out_col = '0;
		r.want.last_element = 1'b1;
		r.want.dim_error = err;
		return r;
	endfunction

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4, 5, 6, 7: return 32'($urandom_range(0, 20'hF_FFFF)) - 32'h0008_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [3:0] rand_dim();
		if ($urandom_range(0, 4) != 0) return 4'($urandom_range(0, 3));
		return 4'($urandom_range(4, 15));
	endfunction

	// another encoding of the same effective size
	function automatic logic [3:0] match_dim(logic [3:0] d);
		case (eff_dim(d))
			1: return 4'($urandom_range(0, 1));
			DIM_MAX: return 4'($urandom_range(DIM_MAX, 15));
			default: return d;
		endcase
	endfunction

	task automatic send_req(input mme_req_t item);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		req_busy = 1'b1;
		live_cnt++;
	endtask

	task automatic issue(input mme_req_t item);
		send_req(item);
		void'(apply_request(item));
	endtask

	task automatic wait_drain();
		req_valid <= 1'b0;
		while (products_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		req_busy = 1'b0;
	endtask

	task automatic write_dim(input logic [2:0] idx, input logic [3:0] val);
		if (req_busy) wait_drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		dim_reg[idx] = val;
	endtask

	task automatic run_phase(input logic [3:0] ar_set, input logic [3:0] ac_set,
			input logic [3:0] br_set, input logic [3:0] bc_set, input int hold);
		int rounds, ar, ac, br, bc, i, j;
		write_dim(REG_A_ROWS, ar_set);
		write_dim(REG_A_COLS, ac_set);
		write_dim(REG_B_ROWS, br_set);
		write_dim(REG_B_COLS, bc_set);
		ar = eff_dim(ar_set);
		ac = eff_dim(ac_set);
		br = eff_dim(br_set);
		bc = eff_dim(bc_set);
		no_idle = ($urandom_range(0, 3) == 0);
		rounds = (hold > 0) ? 3 : $urandom_range(1, 3);
		rx_hold = hold;
		repeat (rounds) begin
			repeat ($urandom_range(0, 2)) begin
				case ($urandom_range(0, 2))
					0: issue(make_req(CMD_WR_A, $urandom_range(0, 7), $urandom_range(0, 7),
						rand_elem()));
					1: issue(make_req(CMD_WR_B, $urandom_range(0, 7), $urandom_range(0, 7),
						rand_elem()));
					default: issue(make_req(CMD_NONE, $urandom_range(0, 7),
						$urandom_range(0, 7), $urandom()));
				endcase
			end
			if (ac == br) begin
				for (i = 0; i < ar; i++)
					for (j = 0; j < ac; j++)
						if (!a_set[{3'(i), 3'(j)}]) issue(make_req(CMD_WR_A, i, j, rand_elem()));
				for (i = 0; i < br; i++)
					for (j = 0; j < bc; j++)
						if (!b_set[{3'(i), 3'(j)}]) issue(make_req(CMD_WR_B, i, j, rand_elem()));
			end
			repeat ($urandom_range(0, 3)) begin
				if ($urandom_range(0, 1))
					issue(make_req(CMD_WR_A, $urandom_range(0, ar - 1),
						$urandom_range(0, ac - 1), rand_elem()));
				else
					issue(make_req(CMD_WR_B, $urandom_range(0, br - 1),
						$urandom_range(0, bc - 1), rand_elem()));
			end
			issue(make_req(CMD_MUL, $urandom_range(0, 7), $urandom_range(0, 7), $urandom()));
		end
	endtask

	initial begin : rsp_side
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 6);
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
			check_product(rsp);
		end
	end

	initial begin : stimulus
		logic [3:0] ac_pick;
		logic [3:0] br_pick;
		dir_tab = '{
			cfg_row(REG_A_ROWS, 4'd0),
			cfg_row(REG_A_COLS, 4'd1),
			cfg_row(REG_B_ROWS, 4'd1),
			cfg_row(REG_B_COLS, 4'd0),
			req_row(CMD_WR_A, 0, 0, 32'h8000_0000),
			req_row(CMD_WR_B, 0, 0, 32'h8000_0000),
			mul_row(32'h7FFF_FFFF, 1'b0),
			req_row(CMD_WR_A, 1, 0, 32'h0000_0005),
			req_row(CMD_NONE, 7, 7, 32'hFFFF_FFFF),
			req_row(CMD_WR_B, 0, 1, 32'h0001_2345),
			req_row(CMD_WR_B, 0, 0, 32'h7FFF_FFFF),
			mul_row(32'h8000_0000, 1'b0),
			req_row(CMD_WR_A, 0, 0, 32'hFFFF_FFFF),
			req_row(CMD_WR_B, 0, 0, 32'h0000_0001),
			mul_row(32'hFFFF_FFFF, 1'b0),
			req_row(CMD_WR_A, 0, 0, 32'h0001_8000),
			req_row(CMD_WR_B, 0, 0, 32'hFFFE_0000),
			mul_row(32'hFFFD_0000, 1'b0),
			cfg_row(REG_B_ROWS, 4'd2),
			mul_row(32'h0000_0000, 1'b1),
			cfg_row(REG_A_COLS, 4'd15),
			cfg_row(REG_B_ROWS, 4'd7),
			mul_row(32'h0000_0000, 1'b1)
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[n]) begin
			if (dir_tab[n].is_cfg) begin
				write_dim(dir_tab[n].cfg_idx, dir_tab[n].cfg_val);
			end else begin
				send_req(dir_tab[n].item);
				if (dir_tab[n].typed) products_due.push_back(dir_tab[n].want);
				else void'(apply_request(dir_tab[n].item));
			end
		end

		// widest output run, then deepest inner sum, then a long receiver stall
		run_phase(4'd15, 4'd1, 4'd1, 4'd8, 0);
		run_phase(4'd1, 4'd15, 4'd8, 4'd1, 0);
		run_phase(4'd3, 4'd2, 4'd2, 4'd3, 200);
		while (live_cnt < ITEM_GOAL) begin
			ac_pick = rand_dim();
			br_pick = ($urandom_range(0, 3) != 0) ? match_dim(ac_pick) : rand_dim();
			run_phase(rand_dim(), ac_pick, br_pick, rand_dim(), 0);
		end
		wait_drain();

		if (bad_cnt == 0 && products_due.size() == 0)
			$display("matrix_multiply_engine_unit_tb passed");
		else
			$display("matrix_multiply_engine_unit_tb failed");
		$finish;
	end

endmodule
